@@ src/im2col_pkg.sv @@
// Shared constants, register codes, state and control types of the im2col gather block.
package im2col_pkg;

    localparam int CHANNELS_DEF   = 4;
    localparam int MAX_DIM_DEF    = 32;
    localparam int MAX_KERNEL_DEF = 7;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int PIXEL_W = 32;
    localparam int VALUE_W = 32;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    localparam int DIM_REG_W  = 6;
    localparam int KER_REG_W  = 3;
    localparam int PAD_REG_W  = 3;
    localparam int STEP_REG_W = 3;
    localparam int PAD_MAX    = (1 << PAD_REG_W) - 1;

    localparam logic [DIM_REG_W-1:0]  HEIGHT_RST = DIM_REG_W'(8);
    localparam logic [DIM_REG_W-1:0]  WIDTH_RST  = DIM_REG_W'(8);
    localparam logic [KER_REG_W-1:0]  KROWS_RST  = KER_REG_W'(3);
    localparam logic [KER_REG_W-1:0]  KCOLS_RST  = KER_REG_W'(3);
    localparam logic [PAD_REG_W-1:0]  PROWS_RST  = PAD_REG_W'(0);
    localparam logic [PAD_REG_W-1:0]  PCOLS_RST  = PAD_REG_W'(0);
    localparam logic [STEP_REG_W-1:0] SROWS_RST  = STEP_REG_W'(1);
    localparam logic [STEP_REG_W-1:0] SCOLS_RST  = STEP_REG_W'(1);

    // Derived configuration settles through three register stages.
    localparam int SETUP_CYCLES = 3;
    localparam int SETUP_CNT_W  = 2;

    typedef enum logic [2:0] {
        REG_IMAGE_HEIGHT = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_KERNEL_ROWS  = 3'd2,
        REG_KERNEL_COLS  = 3'd3,
        REG_PAD_ROWS     = 3'd4,
        REG_PAD_COLS     = 3'd5,
        REG_STEP_ROWS    = 3'd6,
        REG_STEP_COLS    = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_EMIT = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        ST_SETUP,
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic clear;
        logic load_wr;
        logic calc;
        logic read;
        logic deliver;
    } cmd_t;

    typedef struct packed {
        logic cfg_wr;
        logic req_valid;
        logic req_mode;
        logic out_free;
    } status_t;

endpackage

@@ src/im2col_in_if.sv @@
// Request channel: load a pixel or ask for the next column element.
interface im2col_in_if;
    import im2col_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output mode, output pixel, input ready);
    modport sink   (input valid, input mode, input pixel, output ready);
endinterface

@@ src/im2col_out_if.sv @@
// Result channel: one column matrix element with its flags.
interface im2col_out_if;
    import im2col_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               is_padding;
    logic               last;
    logic               empty_res;

    modport source (output valid, output value, output is_padding, output last,
                    output empty_res, input ready);
    modport sink   (input valid, input value, input is_padding, input last,
                    input empty_res, output ready);
endinterface

@@ src/im2col_gather_top.sv @@
// Top level of the im2col gather engine: register port, controller and datapath.
//
// Usage. The req channel carries items with a mode bit. A load item (mode 0)
// writes its pixel into the image store at the next position of a frame laid
// out as channel, row, column; the position wraps after a full frame. An emit
// item (mode 1) returns one element of the column matrix on the rsp channel,
// walking channel, kernel row, kernel column, output row, output column.
// Padding elements come back as zero with is_padding set, the final element
// carries last and the walk then wraps; a geometry with no output positions
// answers every emit item with empty_res.
// Timing. A load item produces nothing. An emit item runs through the accept,
// the coordinate and row offset multiply, the registered store read and the
// output register load, which the controller runs one after another.
// Reset and configuration. After reset, and after every APB register write,
// req.ready stays low while the derived geometry settles; a write also
// restarts the load position and the element walk. When the
// receiver stalls, the result waits in the output register, load items are
// still taken and one more emit item is worked up to the store read, then
// req.ready stays low until the output register frees.
module im2col_gather_top
    import im2col_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int MAX_KERNEL = MAX_KERNEL_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    im2col_in_if.sink             req,
    im2col_out_if.source          rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int KER_W   = $clog2(MAX_KERNEL + 1);
    localparam int SPAN_W  = $clog2(MAX_DIM + 2 * PAD_MAX + 1);
    localparam int PLANE_W = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int TOTAL_W = $clog2(CHANNELS * MAX_DIM * MAX_DIM + 1);

    logic                  cfg_wr;
    logic [DIM_W-1:0]      height, width;
    logic [KER_W-1:0]      krows, kcols;
    logic [PAD_REG_W-1:0]  prows, pcols;
    logic [STEP_REG_W-1:0] srows, scols;
    logic [SPAN_W-1:0]     lim_r, lim_c;
    logic                  empty;
    logic [PLANE_W-1:0]    plane;
    logic [TOTAL_W-1:0]    total;
    logic                  out_free;
    cmd_t                  cmd;
    status_t               status;

    // Writes complete in their access cycle, so the port never waits.
    assign pready = 1'b1;

    im2col_cfg #(
        .CHANNELS   (CHANNELS),
        .MAX_DIM    (MAX_DIM),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg_wr  (cfg_wr),
        .height  (height),
        .width   (width),
        .krows   (krows),
        .kcols   (kcols),
        .prows   (prows),
        .pcols   (pcols),
        .srows   (srows),
        .scols   (scols),
        .lim_r   (lim_r),
        .lim_c   (lim_c),
        .empty   (empty),
        .plane   (plane),
        .total   (total)
    );

    always_comb
    begin
        status.cfg_wr    = cfg_wr;
        status.req_valid = req.valid;
        status.req_mode  = req.mode;
        status.out_free  = out_free;
    end

    im2col_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    assign req.ready = cmd.in_ready;

    im2col_dp #(
        .CHANNELS   (CHANNELS),
        .MAX_DIM    (MAX_DIM),
        .MAX_KERNEL (MAX_KERNEL),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .pixel      (req.pixel),
        .height     (height),
        .width      (width),
        .krows      (krows),
        .kcols      (kcols),
        .prows      (prows),
        .pcols      (pcols),
        .srows      (srows),
        .scols      (scols),
        .lim_r      (lim_r),
        .lim_c      (lim_c),
        .empty      (empty),
        .plane      (plane),
        .total      (total),
        .out_ready  (rsp.ready),
        .out_free   (out_free),
        .out_valid  (rsp.valid),
        .value      (rsp.value),
        .is_padding (rsp.is_padding),
        .last       (rsp.last),
        .empty_res  (rsp.empty_res)
    );

endmodule

@@ src/im2col_cfg.sv @@
// APB register file and the registered geometry values derived from it.
module im2col_cfg
    import im2col_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int MAX_KERNEL = MAX_KERNEL_DEF,
    localparam int DIM_W     = $clog2(MAX_DIM + 1),
    localparam int KER_W     = $clog2(MAX_KERNEL + 1),
    localparam int SPAN_W    = $clog2(MAX_DIM + 2 * PAD_MAX + 1),
    localparam int PLANE_W   = $clog2(MAX_DIM * MAX_DIM + 1),
    localparam int TOTAL_W   = $clog2(CHANNELS * MAX_DIM * MAX_DIM + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  cfg_wr,
    output logic [DIM_W-1:0]      height,
    output logic [DIM_W-1:0]      width,
    output logic [KER_W-1:0]      krows,
    output logic [KER_W-1:0]      kcols,
    output logic [PAD_REG_W-1:0]  prows,
    output logic [PAD_REG_W-1:0]  pcols,
    output logic [STEP_REG_W-1:0] srows,
    output logic [STEP_REG_W-1:0] scols,
    output logic [SPAN_W-1:0]     lim_r,
    output logic [SPAN_W-1:0]     lim_c,
    output logic                  empty,
    output logic [PLANE_W-1:0]    plane,
    output logic [TOTAL_W-1:0]    total
);

    logic [DIM_REG_W-1:0]  height_raw_reg, width_raw_reg;
    logic [KER_REG_W-1:0]  krows_raw_reg, kcols_raw_reg;
    logic [PAD_REG_W-1:0]  prows_raw_reg, pcols_raw_reg;
    logic [STEP_REG_W-1:0] srows_raw_reg, scols_raw_reg;

    logic [DIM_W-1:0]      height_reg, width_reg, height_next, width_next;
    logic [KER_W-1:0]      krows_reg, kcols_reg, krows_next, kcols_next;
    logic [PAD_REG_W-1:0]  prows_reg, pcols_reg;
    logic [STEP_REG_W-1:0] srows_reg, scols_reg, srows_next, scols_next;

    logic [SPAN_W-1:0]     span_r, span_c;
    logic [SPAN_W-1:0]     lim_r_reg, lim_c_reg, lim_r_next, lim_c_next;
    logic                  empty_reg, empty_next;
    logic [PLANE_W-1:0]    plane_reg, plane_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    cfg_reg_t              wr_index, rd_index;

    assign cfg_wr   = psel & penable & pwrite;
    assign wr_index = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);
    assign rd_index = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_raw_reg <= HEIGHT_RST;
            width_raw_reg  <= WIDTH_RST;
            krows_raw_reg  <= KROWS_RST;
            kcols_raw_reg  <= KCOLS_RST;
            prows_raw_reg  <= PROWS_RST;
            pcols_raw_reg  <= PCOLS_RST;
            srows_raw_reg  <= SROWS_RST;
            scols_raw_reg  <= SCOLS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (wr_index)
                REG_IMAGE_HEIGHT: height_raw_reg <= pwdata[DIM_REG_W-1:0];
                REG_IMAGE_WIDTH:  width_raw_reg  <= pwdata[DIM_REG_W-1:0];
                REG_KERNEL_ROWS:  krows_raw_reg  <= pwdata[KER_REG_W-1:0];
                REG_KERNEL_COLS:  kcols_raw_reg  <= pwdata[KER_REG_W-1:0];
                REG_PAD_ROWS:     prows_raw_reg  <= pwdata[PAD_REG_W-1:0];
                REG_PAD_COLS:     pcols_raw_reg  <= pwdata[PAD_REG_W-1:0];
                REG_STEP_ROWS:    srows_raw_reg  <= pwdata[STEP_REG_W-1:0];
                REG_STEP_COLS:    scols_raw_reg  <= pwdata[STEP_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (rd_index)
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_raw_reg);
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_raw_reg);
            REG_KERNEL_ROWS:  prdata = APB_DATA_W'(krows_raw_reg);
            REG_KERNEL_COLS:  prdata = APB_DATA_W'(kcols_raw_reg);
            REG_PAD_ROWS:     prdata = APB_DATA_W'(prows_raw_reg);
            REG_PAD_COLS:     prdata = APB_DATA_W'(pcols_raw_reg);
            REG_STEP_ROWS:    prdata = APB_DATA_W'(srows_raw_reg);
            REG_STEP_COLS:    prdata = APB_DATA_W'(scols_raw_reg);
            default:          prdata = '0;
        endcase
    end

    // First stage: clamp sizes into the supported range, a zero step acts as one.
    always_comb
    begin
        height_next = (height_raw_reg == '0) ? DIM_W'(1) :
                      (32'(height_raw_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) :
                      DIM_W'(height_raw_reg);
        width_next  = (width_raw_reg == '0) ? DIM_W'(1) :
                      (32'(width_raw_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) :
                      DIM_W'(width_raw_reg);
        krows_next  = (32'(krows_raw_reg) > MAX_KERNEL) ? KER_W'(MAX_KERNEL) :
                      KER_W'(krows_raw_reg);
        kcols_next  = (32'(kcols_raw_reg) > MAX_KERNEL) ? KER_W'(MAX_KERNEL) :
                      KER_W'(kcols_raw_reg);
        srows_next  = (srows_raw_reg == '0) ? STEP_REG_W'(1) : srows_raw_reg;
        scols_next  = (scols_raw_reg == '0) ? STEP_REG_W'(1) : scols_raw_reg;
    end

    // Second stage: padded spans, empty flag, last start position per axis and plane size.
    always_comb
    begin
        span_r     = SPAN_W'(height_reg) + SPAN_W'({prows_reg, 1'b0});
        span_c     = SPAN_W'(width_reg) + SPAN_W'({pcols_reg, 1'b0});
        empty_next = (krows_reg == '0) || (kcols_reg == '0) ||
                     (span_r < SPAN_W'(krows_reg)) || (span_c < SPAN_W'(kcols_reg));
        lim_r_next = span_r - SPAN_W'(krows_reg);
        lim_c_next = span_c - SPAN_W'(kcols_reg);
        plane_next = PLANE_W'(height_reg) * PLANE_W'(width_reg);
    end

    // Third stage: pixels in a whole frame.
    assign total_next = TOTAL_W'(plane_reg) * TOTAL_W'(CHANNELS);

    always_ff @(posedge clk)
    begin
        height_reg <= height_next;
        width_reg  <= width_next;
        krows_reg  <= krows_next;
        kcols_reg  <= kcols_next;
        prows_reg  <= prows_raw_reg;
        pcols_reg  <= pcols_raw_reg;
        srows_reg  <= srows_next;
        scols_reg  <= scols_next;
        lim_r_reg  <= lim_r_next;
        lim_c_reg  <= lim_c_next;
        empty_reg  <= empty_next;
        plane_reg  <= plane_next;
        total_reg  <= total_next;
    end

    assign height = height_reg;
    assign width  = width_reg;
    assign krows  = krows_reg;
    assign kcols  = kcols_reg;
    assign prows  = prows_reg;
    assign pcols  = pcols_reg;
    assign srows  = srows_reg;
    assign scols  = scols_reg;
    assign lim_r  = lim_r_reg;
    assign lim_c  = lim_c_reg;
    assign empty  = empty_reg;
    assign plane  = plane_reg;
    assign total  = total_reg;

endmodule

@@ src/im2col_ctrl.sv @@
// Sequencing state machine: setup after configuration, load, and the emit steps.
module im2col_ctrl
    import im2col_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output cmd_t    cmd
);

    state_t                 state_reg, state_next;
    logic [SETUP_CNT_W-1:0] setup_cnt_reg, setup_cnt_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SETUP:
            begin
                if (setup_cnt_reg == SETUP_CNT_W'(SETUP_CYCLES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (status.req_valid && (status.req_mode == MODE_EMIT))
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: state_next = ST_READ;
            ST_READ: state_next = ST_DONE;
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_SETUP;
        endcase
        // A register write restarts the frame and lets the geometry settle.
        if (status.cfg_wr)
        begin
            state_next = ST_SETUP;
        end
    end

    always_comb
    begin
        if ((state_reg == ST_SETUP) && (state_next == ST_SETUP) && !status.cfg_wr)
        begin
            setup_cnt_next = setup_cnt_reg + SETUP_CNT_W'(1);
        end
        else
        begin
            setup_cnt_next = '0;
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.in_ready = (state_reg == ST_IDLE);
        cmd.load_wr  = (state_reg == ST_IDLE) && status.req_valid &&
                       (status.req_mode == MODE_LOAD);
        cmd.clear    = (state_reg == ST_SETUP);
        cmd.calc     = (state_reg == ST_CALC);
        cmd.read     = (state_reg == ST_READ);
        cmd.deliver  = (state_reg == ST_DONE) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SETUP;
            setup_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            setup_cnt_reg <= setup_cnt_next;
        end
    end

endmodule

@@ src/im2col_dp.sv @@
// Datapath: image store, load and element counters, address build and output register.
module im2col_dp
    import im2col_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int MAX_KERNEL = MAX_KERNEL_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int DIM_W     = $clog2(MAX_DIM + 1),
    localparam int KER_W     = $clog2(MAX_KERNEL + 1),
    localparam int SPAN_W    = $clog2(MAX_DIM + 2 * PAD_MAX + 1),
    localparam int PLANE_W   = $clog2(MAX_DIM * MAX_DIM + 1),
    localparam int DEPTH     = CHANNELS * MAX_DIM * MAX_DIM,
    localparam int ADDR_W    = $clog2(DEPTH),
    localparam int TOTAL_W   = $clog2(DEPTH + 1),
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [PIXEL_W-1:0]    pixel,
    input  logic [DIM_W-1:0]      height,
    input  logic [DIM_W-1:0]      width,
    input  logic [KER_W-1:0]      krows,
    input  logic [KER_W-1:0]      kcols,
    input  logic [PAD_REG_W-1:0]  prows,
    input  logic [PAD_REG_W-1:0]  pcols,
    input  logic [STEP_REG_W-1:0] srows,
    input  logic [STEP_REG_W-1:0] scols,
    input  logic [SPAN_W-1:0]     lim_r,
    input  logic [SPAN_W-1:0]     lim_c,
    input  logic                  empty,
    input  logic [PLANE_W-1:0]    plane,
    input  logic [TOTAL_W-1:0]    total,
    input  logic                  out_ready,
    output logic                  out_free,
    output logic                  out_valid,
    output logic [VALUE_W-1:0]    value,
    output logic                  is_padding,
    output logic                  last,
    output logic                  empty_res
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [ADDR_W-1:0] load_pos_reg, load_pos_next;
    logic [CH_W-1:0]   chan_reg, chan_next;
    logic [ADDR_W-1:0] chan_base_reg, chan_base_next;
    logic [KER_W-1:0]  krow_reg, krow_next, kcol_reg, kcol_next;
    logic [SPAN_W-1:0] orow_pos_reg, orow_pos_next, ocol_pos_reg, ocol_pos_next;

    logic [PLANE_W-1:0]    row_off_reg;
    logic [DIM_W-1:0]      col_idx_reg;
    logic [ADDR_W-1:0]     base_snap_reg;
    logic                  pad_reg, last_flag_reg, empty_flag_reg;
    logic [DATA_WIDTH-1:0] rdata_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               pad_out_reg, last_out_reg, empty_out_reg;

    logic [SPAN_W-1:0]   row_sum, col_sum;
    logic [SPAN_W:0]     row_end, col_end;
    logic                row_pad, col_pad;
    logic [DIM_W-1:0]    row_idx, col_idx;
    logic                ocol_last, orow_last, kcol_last, krow_last, chan_last;
    logic                elem_last, load_wrap;
    logic [ADDR_W+1:0]   rd_sum;
    logic [ADDR_W-1:0]   rd_addr;

    // Image coordinate of the current element, relative to the padded origin.
    always_comb
    begin
        row_sum = orow_pos_reg + SPAN_W'(krow_reg);
        col_sum = ocol_pos_reg + SPAN_W'(kcol_reg);
        row_end = (SPAN_W + 1)'(prows) + (SPAN_W + 1)'(height);
        col_end = (SPAN_W + 1)'(pcols) + (SPAN_W + 1)'(width);
        row_pad = (row_sum < SPAN_W'(prows)) || ((SPAN_W + 1)'(row_sum) >= row_end);
        col_pad = (col_sum < SPAN_W'(pcols)) || ((SPAN_W + 1)'(col_sum) >= col_end);
        row_idx = DIM_W'(row_sum - SPAN_W'(prows));
        col_idx = DIM_W'(col_sum - SPAN_W'(pcols));
    end

    always_comb
    begin
        ocol_last = ((SPAN_W + 1)'(ocol_pos_reg) + (SPAN_W + 1)'(scols)) >
                    (SPAN_W + 1)'(lim_c);
        orow_last = ((SPAN_W + 1)'(orow_pos_reg) + (SPAN_W + 1)'(srows)) >
                    (SPAN_W + 1)'(lim_r);
        kcol_last = (kcol_reg == (kcols - KER_W'(1)));
        krow_last = (krow_reg == (krows - KER_W'(1)));
        chan_last = (chan_reg == CH_W'(CHANNELS - 1));
        elem_last = chan_last && krow_last && kcol_last && orow_last && ocol_last;
        load_wrap = ((TOTAL_W'(load_pos_reg) + TOTAL_W'(1)) >= total);
    end

    // Odometer over channel, kernel row, kernel column, output row, output column.
    always_comb
    begin
        load_pos_next  = load_pos_reg;
        chan_next      = chan_reg;
        chan_base_next = chan_base_reg;
        krow_next      = krow_reg;
        kcol_next      = kcol_reg;
        orow_pos_next  = orow_pos_reg;
        ocol_pos_next  = ocol_pos_reg;
        if (cmd.clear)
        begin
            load_pos_next  = '0;
            chan_next      = '0;
            chan_base_next = '0;
            krow_next      = '0;
            kcol_next      = '0;
            orow_pos_next  = '0;
            ocol_pos_next  = '0;
        end
        else
        begin
            if (cmd.load_wr)
            begin
                load_pos_next = load_wrap ? '0 : load_pos_reg + ADDR_W'(1);
            end
            if (cmd.calc && !empty)
            begin
                if (!ocol_last)
                begin
                    ocol_pos_next = ocol_pos_reg + SPAN_W'(scols);
                end
                else
                begin
                    ocol_pos_next = '0;
                    if (!orow_last)
                    begin
                        orow_pos_next = orow_pos_reg + SPAN_W'(srows);
                    end
                    else
                    begin
                        orow_pos_next = '0;
                        if (!kcol_last)
                        begin
                            kcol_next = kcol_reg + KER_W'(1);
                        end
                        else
                        begin
                            kcol_next = '0;
                            if (!krow_last)
                            begin
                                krow_next = krow_reg + KER_W'(1);
                            end
                            else
                            begin
                                krow_next = '0;
                                if (chan_last)
                                begin
                                    chan_next      = '0;
                                    chan_base_next = '0;
                                end
                                else
                                begin
                                    chan_next      = chan_reg + CH_W'(1);
                                    chan_base_next = chan_base_reg + ADDR_W'(plane);
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg  <= '0;
            chan_reg      <= '0;
            chan_base_reg <= '0;
            krow_reg      <= '0;
            kcol_reg      <= '0;
            orow_pos_reg  <= '0;
            ocol_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            load_pos_reg  <= load_pos_next;
            chan_reg      <= chan_next;
            chan_base_reg <= chan_base_next;
            krow_reg      <= krow_next;
            kcol_reg      <= kcol_next;
            orow_pos_reg  <= orow_pos_next;
            ocol_pos_reg  <= ocol_pos_next;
            if (cmd.deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Address pieces are registered so the multiply and the final add sit in
    // different cycles.
    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            row_off_reg    <= PLANE_W'(row_idx) * PLANE_W'(width);
            col_idx_reg    <= col_idx;
            base_snap_reg  <= chan_base_reg;
            pad_reg        <= row_pad || col_pad;
            last_flag_reg  <= elem_last;
            empty_flag_reg <= empty;
        end
    end

    assign rd_sum  = (ADDR_W + 2)'(base_snap_reg) + (ADDR_W + 2)'(row_off_reg) +
                     (ADDR_W + 2)'(col_idx_reg);
    assign rd_addr = rd_sum[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            mem[load_pos_reg] <= DATA_WIDTH'(pixel);
        end
        if (cmd.read)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.deliver)
        begin
            value_reg     <= (pad_reg || empty_flag_reg) ? '0 : VALUE_W'(rdata_reg);
            pad_out_reg   <= pad_reg && !empty_flag_reg;
            last_out_reg  <= last_flag_reg && !empty_flag_reg;
            empty_out_reg <= empty_flag_reg;
        end
    end

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign is_padding = pad_out_reg;
    assign last       = last_out_reg;
    assign empty_res  = empty_out_reg;

endmodule
